FILE: design/ntwa_pkg.sv
`default_nettype none
package ntwa_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int TIME_BITS     = 32;
  localparam int TIMEOUT_BITS  = 32;
  localparam int ADDR_BITS     = 16;
  localparam int COUNT_BITS    = 4;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(640);
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX     = '1;

  localparam logic [1:0] KIND_HEARD = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_SWEEP = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] address;
  } item_t;

  typedef struct packed {
    logic                  present;
    logic                  added;
    logic                  table_full;
    logic [COUNT_BITS-1:0] removed_count;
  } result_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [TIME_BITS-1:0] heard_time;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             vld_en;
    logic [IDX_W-1:0] vld_idx;
    logic             vld_val;
  } store_ctl_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_t;

endpackage
`default_nettype wire

FILE: design/ntwa_store.sv
`default_nettype none
module ntwa_store (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire ntwa_pkg::store_ctl_t                   ctl_i,
  input  wire ntwa_pkg::entry_t                       wr_data_i,
  input  wire logic [ntwa_pkg::IDX_W-1:0]             rd_idx_i,
  output ntwa_pkg::entry_t                            rd_data_o,
  output logic [ntwa_pkg::TABLE_ENTRIES-1:0]          valid_o
);
  import ntwa_pkg::*;

  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_data_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_idx] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.vld_en) begin
      valid_q[ctl_i.vld_idx] <= ctl_i.vld_val;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule
`default_nettype wire

FILE: design/ntwa_cmp.sv
`default_nettype none
module ntwa_cmp (
  input  wire logic [ntwa_pkg::TIME_BITS-1:0]    time_now_i,
  input  wire logic [ntwa_pkg::TIMEOUT_BITS-1:0] timeout_i,
  input  wire logic [ntwa_pkg::ADDR_BITS-1:0]    addr_i,
  input  wire ntwa_pkg::entry_t                  entry_i,
  output ntwa_pkg::cmp_t                         cmp_o
);
  import ntwa_pkg::*;

  logic [TIME_BITS-1:0] age;

  // age wraps with the time counter
  assign age           = time_now_i - entry_i.heard_time;
  assign cmp_o.expired = CMP_W'(age) > CMP_W'(timeout_i);
  assign cmp_o.match   = (entry_i.address == addr_i);

endmodule
`default_nettype wire

FILE: design/neighbour_table_with_aging_top.sv
`default_nettype none
// Neighbor table with timeout aging.
// Command channel: item_i (kind, address) is taken on a clock edge with start
// high and busy low. Kinds: heard, query, tick, sweep.
// Result channel: result_o is shown for exactly one cycle with done_o high;
// the receiver cannot stall it, so it must take the word in that cycle.
// Config channel: cfg_data_i is written to the timeout register when
// cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high. Write
// only while no command is in flight.
// Timing: a tick goes from acceptance through the finish state to its result.
// Heard, query and sweep walk the table one entry per cycle through one shared
// compare unit and a registered read port, then pass the finish state to the
// result; busy meanwhile. Next command may be taken in the cycle the result is
// shown.
// Reset: table empty, time counter zero, timeout 640, no result pending.
module neighbour_table_with_aging_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ntwa_pkg::item_t                  item_i,
  output logic                                  done_o,
  output ntwa_pkg::result_t                     result_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ntwa_pkg::TIMEOUT_BITS-1:0] cfg_data_i
);
  import ntwa_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]              state_q, state_d;
  item_t                   item_q, item_d;
  logic [TIME_BITS-1:0]    time_now_q, time_now_d;
  logic [TIMEOUT_BITS-1:0] timeout_q;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]        ev_idx_q, ev_idx_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    free_q, free_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic [COUNT_BITS-1:0]   rm_cnt_q, rm_cnt_d;
  logic                    done_q, done_d;
  result_t                 result_q, result_d;

  store_ctl_t               ctl;
  entry_t                   wr_data;
  entry_t                   rd_data;
  logic [IDX_W-1:0]         rd_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  cmp_t                     cmp;
  logic                     ev_valid;

  ntwa_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .wr_data_i (wr_data),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .valid_o   (valid)
  );

  ntwa_cmp u_cmp (
    .time_now_i (time_now_q),
    .timeout_i  (timeout_q),
    .addr_i     (item_q.address),
    .entry_i    (rd_data),
    .cmp_o      (cmp)
  );

  assign rd_idx   = rd_cnt_q[IDX_W-1:0];
  assign ev_valid = valid[ev_idx_q];
  assign wr_data  = '{address: item_q.address, heard_time: time_now_q};

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    time_now_d = time_now_q;
    rd_cnt_d   = rd_cnt_q;
    ev_vld_d   = 1'b0;
    ev_idx_d   = ev_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    rm_cnt_d   = rm_cnt_q;
    done_d     = 1'b0;
    result_d   = result_q;
    ctl        = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d   = item_i;
          rd_cnt_d = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          rm_cnt_d = '0;
          if (item_i.kind == KIND_TICK) begin
            time_now_d = time_now_q + TIME_BITS'(1);
            state_d    = ST_FINISH;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // read entry at rd_cnt, evaluate the one read last cycle
        if (rd_cnt_q != CNT_W'(TABLE_ENTRIES)) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx;
        end else if (!ev_vld_q) begin
          state_d = ST_FINISH;
        end
        if (ev_vld_q) begin
          if (ev_valid && cmp.match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = ev_idx_q;
          end
          if (!ev_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = ev_idx_q;
          end
          if (item_q.kind == KIND_SWEEP && ev_valid && cmp.expired) begin
            ctl.vld_en  = 1'b1;
            ctl.vld_idx = ev_idx_q;
            ctl.vld_val = 1'b0;
            if (rm_cnt_q != COUNT_MAX) begin
              rm_cnt_d = rm_cnt_q + COUNT_BITS'(1);
            end
          end
        end
      end
      ST_FINISH: begin
        result_d = '0;
        case (item_q.kind)
          KIND_HEARD: begin
            if (hit_q) begin
              result_d.present = 1'b1;
              ctl.wr_en        = 1'b1;
              ctl.wr_idx       = hit_idx_q;
            end else if (free_q) begin
              result_d.added = 1'b1;
              ctl.wr_en      = 1'b1;
              ctl.wr_idx     = free_idx_q;
              ctl.vld_en     = 1'b1;
              ctl.vld_idx    = free_idx_q;
              ctl.vld_val    = 1'b1;
            end else begin
              result_d.table_full = 1'b1;
            end
          end
          KIND_QUERY: result_d.present       = hit_q;
          KIND_SWEEP: result_d.removed_count = rm_cnt_q;
          default:    result_d               = '0;
        endcase
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      time_now_q <= '0;
      timeout_q  <= TIMEOUT_RESET;
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      rm_cnt_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      time_now_q <= time_now_d;
      rd_cnt_q   <= rd_cnt_d;
      ev_vld_q   <= ev_vld_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      rm_cnt_q   <= rm_cnt_d;
      done_q     <= done_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ev_idx_q   <= ev_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    result_q   <= result_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign result_o    = result_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

FILE: sim/neighbour_table_with_aging_top_tb.sv
`default_nettype none
module neighbour_table_with_aging_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntwa_pkg::*;

  localparam int RESULT_LATENCY = TABLE_ENTRIES + 3;
  localparam int POOL_SIZE      = 12;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  item_t                   item_i      = '0;
  logic                    done_o;
  result_t                 result_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [TIMEOUT_BITS-1:0] cfg_data_i  = '0;

  neighbour_table_with_aging_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // mirror of the neighbor table
  logic                    nb_valid [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0]    nb_addr  [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]    nb_heard [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]    now_ticks;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  logic [ADDR_BITS-1:0]    addr_pool [POOL_SIZE];

  result_t expected_results [$];
  int      error_count     = 0;
  int      sender_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic result_t apply_neighbour_item(item_t it);
    result_t              r;
    int                   hit;
    int                   free_slot;
    logic [TIME_BITS-1:0] age;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    case (it.kind)
      KIND_HEARD, KIND_QUERY: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (nb_valid[i] && nb_addr[i] == it.address && hit < 0) hit = i;
          if (!nb_valid[i] && free_slot < 0) free_slot = i;
        end
        r.present = (hit >= 0);
        if (it.kind == KIND_HEARD) begin
          if (hit >= 0) begin
            nb_heard[hit] = now_ticks;
          end else if (free_slot >= 0) begin
            nb_valid[free_slot] = 1'b1;
            nb_addr[free_slot]  = it.address;
            nb_heard[free_slot] = now_ticks;
            r.added             = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        now_ticks = now_ticks + 1'b1;
      end
      default: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (nb_valid[i]) begin
            age = now_ticks - nb_heard[i];
            if (CMP_W'(age) > CMP_W'(timeout_ticks)) begin
              nb_valid[i] = 1'b0;
              if (r.removed_count != COUNT_MAX) r.removed_count = r.removed_count + 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic item_t make_item(logic [1:0] k, logic [ADDR_BITS-1:0] a);
    item_t it;
    it.kind    = k;
    it.address = a;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    roll;
    roll       = $urandom_range(99);
    it.address = ADDR_BITS'($urandom_range(65535));
    if (roll < 35) begin
      it.kind = KIND_HEARD;
    end else if (roll < 60) begin
      it.kind = KIND_QUERY;
    end else if (roll < 85) begin
      it.kind = KIND_TICK;
    end else begin
      it.kind = KIND_SWEEP;
    end
    if ((it.kind == KIND_HEARD || it.kind == KIND_QUERY) && $urandom_range(9) < 8) begin
      it.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return it;
  endfunction

  // start stays high after acceptance so back-to-back words need no toggle
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(apply_neighbour_item(it));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    timeout_ticks = value;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    result_t exp;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word %p", $time, result_o);
      end else begin
        exp = expected_results.pop_front();
        if (result_o.present !== exp.present || result_o.added !== exp.added ||
            result_o.table_full !== exp.table_full ||
            result_o.removed_count !== exp.removed_count) begin
          error_count++;
          $display("%0t: expected present=%0b added=%0b full=%0b removed=%0d, got %0b %0b %0b %0d",
                   $time, exp.present, exp.added, exp.table_full, exp.removed_count,
                   result_o.present, result_o.added, result_o.table_full,
                   result_o.removed_count);
        end
      end
    end
  end

  // entries expire only after more than 640 ticks at reset
  task automatic test_reset_timeout();
    send_item(make_item(KIND_HEARD, 16'h0A0A));
    repeat (640) send_item(make_item(KIND_TICK, ADDR_BITS'($urandom_range(65535))));
    send_item(make_item(KIND_SWEEP, 16'h0000));
    send_item(make_item(KIND_TICK, 16'hFFFF));
    send_item(make_item(KIND_SWEEP, 16'hFFFF));
  endtask

  task automatic test_heard_and_query();
    send_item(make_item(KIND_QUERY, 16'h0000));
    send_item(make_item(KIND_HEARD, 16'h0000));
    send_item(make_item(KIND_HEARD, 16'hFFFF));
    send_item(make_item(KIND_HEARD, 16'h0000));
    send_item(make_item(KIND_QUERY, 16'hFFFF));
    send_item(make_item(KIND_QUERY, 16'h5555));
    send_item(make_item(KIND_HEARD, 16'h5555));
    send_item(make_item(KIND_HEARD, 16'hAAAA));
    send_item(make_item(KIND_QUERY, 16'hAAAA));
  endtask

  task automatic test_table_full();
    send_item(make_item(KIND_TICK, 16'hFFFF));
    send_item(make_item(KIND_SWEEP, 16'hAAAA));
    send_item(make_item(KIND_HEARD, 16'h0001));
    send_item(make_item(KIND_HEARD, 16'h8000));
    send_item(make_item(KIND_HEARD, 16'h1234));
    send_item(make_item(KIND_HEARD, 16'h00FF));
    send_item(make_item(KIND_HEARD, 16'h7777));
    send_item(make_item(KIND_HEARD, 16'h8000));
  endtask

  task automatic test_timeout_extremes();
    write_timeout('0);
    send_item(make_item(KIND_SWEEP, 16'h5A5A));
    send_item(make_item(KIND_TICK, 16'h0000));
    send_item(make_item(KIND_SWEEP, 16'hA5A5));
    write_timeout('1);
    send_item(make_item(KIND_HEARD, 16'h4242));
    send_item(make_item(KIND_TICK, 16'h1111));
    send_item(make_item(KIND_SWEEP, 16'h2222));
    write_timeout(TIMEOUT_BITS'(1));
    send_item(make_item(KIND_TICK, 16'h3333));
    send_item(make_item(KIND_SWEEP, 16'h4444));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input logic [TIMEOUT_BITS-1:0] timeout);
    write_timeout(timeout);
    sender_idle_pct = idle_pct;
    foreach (addr_pool[i]) addr_pool[i] = ADDR_BITS'($urandom_range(65535));
    repeat (count) send_item(random_item());
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      nb_valid[i] = 1'b0;
      nb_addr[i]  = '0;
      nb_heard[i] = '0;
    end
    now_ticks     = '0;
    timeout_ticks = TIMEOUT_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_timeout();
    test_heard_and_query();
    test_table_full();
    test_timeout_extremes();
    test_random_traffic(15, 0, $urandom_range(2, 12));
    test_random_traffic(15, 49, TIMEOUT_BITS'(1));
    test_random_traffic(10, 0, '1);
    test_random_traffic(15, 21, $urandom_range(3, 30));
    wait_idle();
    repeat (RESULT_LATENCY) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: neighbour_table_with_aging_top.f
design/ntwa_pkg.sv
design/ntwa_store.sv
design/ntwa_cmp.sv
design/neighbour_table_with_aging_top.sv
sim/neighbour_table_with_aging_top_tb.sv
